// File: rtl/core/ftsd_pkg.sv
// ----------------------------------------------------------------------------
// Frame time spike detector package
// Widths, constants, register indexes and shared types of the detector.
// ----------------------------------------------------------------------------
package ftsd_pkg;

   localparam int DATA_W         = 20;
   localparam int MULT_W         = 12;
   localparam int HOLD_W         = 20;
   localparam int CSR_DATA_W     = 20;
   localparam int CSR_IDX_W      = 1;
   localparam int FRAC_W         = 8;
   localparam int WINDOW_DEFAULT = 64;
   localparam int MIN_SAMPLES    = 5;

   localparam logic [DATA_W-1:0] MAX_INTERVAL_US = DATA_W'(1000000);
   localparam logic [MULT_W-1:0] MULT_RESET      = MULT_W'(640);
   localparam logic [HOLD_W-1:0] HOLD_RESET      = HOLD_W'(75000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPIKE_MULT = 1'b0,
      CSR_HOLD_DUR   = 1'b1
   } csr_index_type;

   // control bits of one request moving down the pipeline
   typedef struct packed {
      logic valid;
      logic ok;
   } stage_ctl_type;

endpackage

// File: rtl/core/ftsd_if.sv
// ----------------------------------------------------------------------------
// Frame time spike detector channels
// Request channel (one interval sample) and response channel (flags).
// ----------------------------------------------------------------------------
interface ftsd_req_if;
   logic                        valid;
   logic                        ready;
   logic [ftsd_pkg::DATA_W-1:0] interval_us;

   modport source (output valid, output interval_us, input ready);
   modport sink   (input valid, input interval_us, output ready);
endinterface

interface ftsd_rsp_if;
   logic valid;
   logic ready;
   logic sample_accepted;
   logic spike_active;
   logic spike_started;

   modport source (output valid, output sample_accepted, output spike_active,
                   output spike_started, input ready);
   modport sink   (input valid, input sample_accepted, input spike_active,
                   input spike_started, output ready);
endinterface

// File: rtl/core/ftsd_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one window sample and hands it to the next cell on every shift.
// ----------------------------------------------------------------------------
module ftsd_cell (
   input  logic                        clock,
   input  logic                        shift,
   input  logic [ftsd_pkg::DATA_W-1:0] sample_d,
   output logic [ftsd_pkg::DATA_W-1:0] sample_q
);

   logic [ftsd_pkg::DATA_W-1:0] sample_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         sample_ff <= sample_d;
      end
   end

   assign sample_q = sample_ff;

endmodule

// File: rtl/core/ftsd_window.sv
// ----------------------------------------------------------------------------
// Sliding window
// Row of sample cells with running count and sum; first pipeline stage.
// ----------------------------------------------------------------------------
module ftsd_window #(
   parameter int WINDOW = ftsd_pkg::WINDOW_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic                        adv,
   input  logic [ftsd_pkg::DATA_W-1:0] sample,
   output ftsd_pkg::stage_ctl_type     ctl_q,
   output logic [ftsd_pkg::DATA_W-1:0] sample_q,
   output logic [$clog2(WINDOW+1)-1:0] count_q,
   output logic [ftsd_pkg::DATA_W+$clog2(WINDOW+1)-1:0] sum_q
);

   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = ftsd_pkg::DATA_W + CNT_W;

   logic [ftsd_pkg::DATA_W-1:0] chain [WINDOW+1];
   logic                        ok;
   logic                        shift;
   logic                        full;
   ftsd_pkg::stage_ctl_type     ctl_ff, ctl_in;
   logic [ftsd_pkg::DATA_W-1:0] sample_ff;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [SUM_W-1:0]            sum_ff, sum_in;

   assign ok    = (sample != '0) && (sample <= ftsd_pkg::MAX_INTERVAL_US);
   assign shift = load && ok;
   assign full  = (count_ff == CNT_W'(WINDOW));

   assign chain[0] = sample;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      ftsd_cell u_cell (
         .clock    (clock),
         .shift    (shift),
         .sample_d (chain[i]),
         .sample_q (chain[i+1])
      );
   end

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff + SUM_W'(sample);
      if (full) begin
         sum_in = sum_in - SUM_W'(chain[WINDOW]);
      end else begin
         count_in = count_ff + CNT_W'(1);
      end
      ctl_in       = ctl_ff;
      if (adv) begin
         ctl_in.valid = load;
         ctl_in.ok    = ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         ctl_ff <= ctl_in;
         if (shift) begin
            count_ff <= count_in;
            sum_ff   <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= sample;
      end
   end

   assign ctl_q    = ctl_ff;
   assign sample_q = sample_ff;
   assign count_q  = count_ff;
   assign sum_q    = sum_ff;

endmodule

// File: rtl/core/ftsd_judge.sv
// ----------------------------------------------------------------------------
// Spike judge
// Products stage, then threshold compare, hold timer and response register.
// ----------------------------------------------------------------------------
module ftsd_judge #(
   parameter int WINDOW = ftsd_pkg::WINDOW_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv2,
   input  logic                        adv3,
   input  ftsd_pkg::stage_ctl_type     ctl1,
   input  logic [ftsd_pkg::DATA_W-1:0] sample1,
   input  logic [$clog2(WINDOW+1)-1:0] count1,
   input  logic [ftsd_pkg::DATA_W+$clog2(WINDOW+1)-1:0] sum1,
   input  logic [ftsd_pkg::MULT_W-1:0] mult,
   input  logic [ftsd_pkg::HOLD_W-1:0] hold,
   output logic                        valid2,
   output logic                        rsp_valid,
   output logic                        rsp_accepted,
   output logic                        rsp_active,
   output logic                        rsp_started
);

   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = ftsd_pkg::DATA_W + CNT_W;
   localparam int PROD_W = ftsd_pkg::DATA_W + CNT_W;
   localparam int CMP_W  = SUM_W + ftsd_pkg::MULT_W;

   ftsd_pkg::stage_ctl_type     ctl2_ff, ctl2_in;
   logic [ftsd_pkg::DATA_W-1:0] sample2_ff;
   logic [PROD_W-1:0]           lhs2_ff;
   logic [CMP_W-1:0]            rhs2_ff;
   logic                        enough2_ff;
   logic [CMP_W-1:0]            lhs_full;
   logic                        flag_ff, flag_in;
   logic [ftsd_pkg::HOLD_W-1:0] timer_ff, timer_in;
   logic                        v3_ff, v3_in;
   logic                        acc3_ff, act3_ff, start3_ff;
   logic                        start_in;

   // stage 2: register both sides of the cross-multiplied compare
   always_comb begin
      ctl2_in = ctl2_ff;
      if (adv2) begin
         ctl2_in = ctl1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else begin
         ctl2_ff <= ctl2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && ctl1.valid) begin
         sample2_ff <= sample1;
         lhs2_ff    <= PROD_W'(sample1 * count1);
         rhs2_ff    <= CMP_W'(sum1 * mult);
         enough2_ff <= (count1 >= CNT_W'(ftsd_pkg::MIN_SAMPLES));
      end
   end

   // stage 3: decide, run the hold timer, fill the response register
   assign lhs_full = CMP_W'({lhs2_ff, {ftsd_pkg::FRAC_W{1'b0}}});

   always_comb begin
      flag_in  = flag_ff;
      timer_in = timer_ff;
      start_in = 1'b0;
      if (ctl2_ff.ok) begin
         if (flag_ff) begin
            if (timer_ff <= sample2_ff) begin
               flag_in  = 1'b0;
               timer_in = '0;
            end else begin
               timer_in = timer_ff - sample2_ff;
            end
         end else if (enough2_ff && (lhs_full > rhs2_ff)) begin
            flag_in  = 1'b1;
            timer_in = hold;
            start_in = 1'b1;
         end
      end
      v3_in = v3_ff;
      if (adv3) begin
         v3_in = ctl2_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff    <= 1'b0;
         flag_ff  <= 1'b0;
         timer_ff <= '0;
      end else begin
         v3_ff <= v3_in;
         if (adv3 && ctl2_ff.valid) begin
            flag_ff  <= flag_in;
            timer_ff <= timer_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv3 && ctl2_ff.valid) begin
         acc3_ff   <= ctl2_ff.ok;
         act3_ff   <= flag_in;
         start3_ff <= start_in;
      end
   end

   assign valid2       = ctl2_ff.valid;
   assign rsp_valid    = v3_ff;
   assign rsp_accepted = acc3_ff;
   assign rsp_active   = act3_ff;
   assign rsp_started  = start3_ff;

   a_start_active: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && start3_ff) |-> (act3_ff && acc3_ff))
      else $error("spike start without active flag or accepted sample");

   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      !flag_ff |-> (timer_ff == '0))
      else $error("hold timer nonzero while no spike");

   a_reject_keeps_flag: assert property (@(posedge clock) disable iff (reset)
      (adv3 && ctl2_ff.valid && !ctl2_ff.ok) |=> ($stable(flag_ff) && $stable(timer_ff)))
      else $error("rejected sample changed spike state");

   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      (adv3 && ctl2_ff.valid && !ctl2_ff.ok) |=> (!acc3_ff && !start3_ff))
      else $error("rejected sample reported as processed");

endmodule

// File: rtl/core/frame_time_spike_detector.sv
// ----------------------------------------------------------------------------
// Frame time spike detector
// Flags frame interval samples that jump above the window average.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one interval sample in microseconds per request; rsp returns
//   one response per request, in order: sample_accepted, spike_active and
//   spike_started. Samples of zero or above one second are reported with
//   sample_accepted low and leave the window and the spike state alone.
//   csr_* writes the threshold multiplier (Q4.8) and the hold length; write
//   them only while no request is in flight.
// Timing:
//   An accepted request passes the window stage, the product stage and the
//   response register, in that order, and its response is then valid.
//   One request per cycle is taken while the pipeline flows; the rate is set
//   by the window row, which shifts all cells and updates the running sum
//   together for each accepted sample.
// Reset and stall:
//   Reset empties the window, clears the spike flag and hold timer and
//   restores the register defaults. While rsp is stalled, the response
//   register holds; req.ready stays high until every stage is occupied.
// ----------------------------------------------------------------------------
module frame_time_spike_detector #(
   parameter int WINDOW = ftsd_pkg::WINDOW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   ftsd_req_if.sink                        req,
   ftsd_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  logic [ftsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ftsd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = ftsd_pkg::DATA_W + CNT_W;

   logic [ftsd_pkg::MULT_W-1:0] mult_ff, mult_in;
   logic [ftsd_pkg::HOLD_W-1:0] hold_ff, hold_in;

   ftsd_pkg::stage_ctl_type     ctl1;
   logic [ftsd_pkg::DATA_W-1:0] sample1;
   logic [CNT_W-1:0]            count1;
   logic [SUM_W-1:0]            sum1;
   logic                        valid2;
   logic                        adv1, adv2, adv3;
   logic                        req_take;

   // Stall chain: a stage moves when it is empty or the stage behind moves.
   assign adv3      = !rsp.valid || rsp.ready;
   assign adv2      = !valid2 || adv3;
   assign adv1      = !ctl1.valid || adv2;
   assign req.ready = adv1;
   assign req_take  = req.valid && adv1;

   // Register file decode
   always_comb begin
      mult_in = mult_ff;
      hold_in = hold_ff;
      if (csr_we) begin
         unique case (ftsd_pkg::csr_index_type'(csr_index))
            ftsd_pkg::CSR_SPIKE_MULT: mult_in = csr_wdata[ftsd_pkg::MULT_W-1:0];
            ftsd_pkg::CSR_HOLD_DUR:   hold_in = csr_wdata[ftsd_pkg::HOLD_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff <= ftsd_pkg::MULT_RESET;
         hold_ff <= ftsd_pkg::HOLD_RESET;
      end else begin
         mult_ff <= mult_in;
         hold_ff <= hold_in;
      end
   end

   // Stage 1: shift the sample into the cell row, update count and sum
   ftsd_window #(
      .WINDOW (WINDOW)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .load     (req_take),
      .adv      (adv1),
      .sample   (req.interval_us),
      .ctl_q    (ctl1),
      .sample_q (sample1),
      .count_q  (count1),
      .sum_q    (sum1)
   );

   // Stages 2 and 3: products, threshold, hold timer, response register
   ftsd_judge #(
      .WINDOW (WINDOW)
   ) u_judge (
      .clock        (clock),
      .reset        (reset),
      .adv2         (adv2),
      .adv3         (adv3),
      .ctl1         (ctl1),
      .sample1      (sample1),
      .count1       (count1),
      .sum1         (sum1),
      .mult         (mult_ff),
      .hold         (hold_ff),
      .valid2       (valid2),
      .rsp_valid    (rsp.valid),
      .rsp_accepted (rsp.sample_accepted),
      .rsp_active   (rsp.spike_active),
      .rsp_started  (rsp.spike_started)
   );

endmodule
